// ===== rtl/core/spa_pkg.sv =====
`timescale 1ns / 1ps

package spa_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;

  localparam logic [3:0] GRANULE_LOG2_RST = 4'd4;
  localparam logic [6:0] HEADER_BYTES_RST = 7'd8;

  // request codes
  localparam logic MODE_ALLOC = 1'b0;

  // bin index carried through the queue, wide enough for the largest bin count
  localparam int QBIN_W = 6;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BIG   = 2'd3
  } spa_status_t;

  typedef enum logic [1:0] {
    JOB_DONE  = 2'd0,
    JOB_ALLOC = 2'd1,
    JOB_FREE  = 2'd2
  } spa_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } spa_back_state_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] req_size;
    logic [8:0]  handle;
    logic        handle_is_null;
  } spa_in_t;

  typedef struct packed {
    spa_status_t status;
    logic [8:0]  out_handle;
    logic [3:0]  bin_number;
  } spa_out_t;

  // classified request handed from front to back
  typedef struct packed {
    spa_kind_t         kind;
    spa_status_t       status;
    logic [QBIN_W-1:0] bin_idx;
    logic [8:0]        handle;
  } spa_job_t;

endpackage

// ===== rtl/core/spa_front.sv =====
`timescale 1ns / 1ps

module spa_front #(
  parameter int NUM_BINS      = 8,
  parameter int SLOTS_PER_BIN = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [spa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              cfg_ready,
  input  spa_pkg::spa_in_t                  in_word,
  output spa_pkg::spa_job_t                 job
);
  import spa_pkg::*;

  localparam int TOTAL = NUM_BINS * SLOTS_PER_BIN;

  logic [3:0]  granule_r;
  logic [6:0]  header_r;
  logic [17:0] round_sum;
  logic [17:0] bin_raw;
  logic        too_big;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granule_r <= GRANULE_LOG2_RST;
      header_r  <= HEADER_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRANULE_LOG2: granule_r <= cfg_data[3:0];
        CFG_HEADER_BYTES: header_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // size class: header added, rounded up to the granule
  assign round_sum = 18'(in_word.req_size) + 18'(header_r)
                   + (18'(1) << granule_r) - 18'(1);
  assign bin_raw   = round_sum >> granule_r;
  assign too_big   = (bin_raw == '0) || (32'(bin_raw) > NUM_BINS);

  // classify the request
  always_comb begin
    job         = '0;
    job.kind    = JOB_DONE;
    job.status  = ST_NULL;
    if (in_word.mode == MODE_ALLOC) begin
      if (in_word.req_size == '0) begin
        job.status = ST_NULL;
      end else if (too_big) begin
        job.status = ST_BIG;
      end else begin
        job.kind    = JOB_ALLOC;
        job.status  = ST_OK;
        job.bin_idx = QBIN_W'(bin_raw - 18'(1));
      end
    end else begin
      if (in_word.handle_is_null || (32'(in_word.handle) >= TOTAL)) begin
        job.status = ST_NULL;
      end else begin
        job.kind   = JOB_FREE;
        job.status = ST_OK;
        job.handle = in_word.handle;
      end
    end
  end

endmodule

// ===== rtl/core/spa_queue.sv =====
`timescale 1ns / 1ps

module spa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spa_pkg::spa_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output spa_pkg::spa_job_t q_job
);
  import spa_pkg::*;

  spa_job_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QPTR_W:0]     count_r;
  logic [QPTR_W:0]     count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = slots_r[rd_ptr_r];

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/spa_back.sv =====
`timescale 1ns / 1ps

module spa_back #(
  parameter int NUM_BINS      = 8,
  parameter int SLOTS_PER_BIN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  spa_pkg::spa_job_t q_job,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output spa_pkg::spa_out_t out_word
);
  import spa_pkg::*;

  localparam int TOTAL = NUM_BINS * SLOTS_PER_BIN;
  localparam int LW    = $clog2(TOTAL + 1);
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SW    = (SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(TOTAL);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_BIN - 1);

  spa_back_state_t state_r;
  spa_back_state_t state_nxt;
  spa_job_t        cur_r;
  spa_job_t        cur_nxt;
  logic [LW-1:0]   head_r;
  logic [LW-1:0]   head_nxt;
  logic [AW-1:0]   clr_h_r;
  logic [AW-1:0]   clr_h_nxt;
  logic [SW-1:0]   clr_s_r;
  logic [SW-1:0]   clr_s_nxt;
  logic            out_valid_r;
  spa_out_t        out_word_r;
  spa_out_t        out_nxt;
  logic            out_load;
  logic            out_free;

  // free-list links and chunk tags
  logic [LW-1:0]   link_mem [TOTAL];
  logic [BW-1:0]   tag_mem  [TOTAL];
  logic [LW-1:0]   link_rd_r;
  logic [BW-1:0]   tag_rd_r;
  logic            link_rd_en;
  logic [AW-1:0]   link_ra;
  logic            link_we;
  logic [AW-1:0]   link_wa;
  logic [LW-1:0]   link_wd;
  logic            tag_rd_en;
  logic [AW-1:0]   tag_ra;
  logic            tag_we;
  logic [AW-1:0]   tag_wa;
  logic [BW-1:0]   tag_wd;

  // bin heads, one read and one write port
  logic [LW-1:0]   heads_r [NUM_BINS];
  logic [BW-1:0]   head_ri;
  logic [LW-1:0]   head_rv;
  logic            heads_we;
  logic [BW-1:0]   heads_wi;
  logic [LW-1:0]   heads_wd;

  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign head_ri   = (state_r == BK_IDLE) ? BW'(cur_nxt.bin_idx) : tag_rd_r;
  assign head_rv   = heads_r[head_ri];

  // sequencer: clear links, pick a job, commit it
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    head_nxt   = head_r;
    clr_h_nxt  = clr_h_r;
    clr_s_nxt  = clr_s_r;
    q_pop      = 1'b0;
    link_rd_en = 1'b0;
    link_ra    = AW'(head_rv);
    link_we    = 1'b0;
    link_wa    = AW'(cur_r.handle);
    link_wd    = head_rv;
    tag_rd_en  = 1'b0;
    tag_ra     = AW'(q_job.handle);
    tag_we     = 1'b0;
    tag_wa     = AW'(head_r);
    tag_wd     = BW'(cur_r.bin_idx);
    heads_we   = 1'b0;
    heads_wi   = BW'(cur_r.bin_idx);
    heads_wd   = link_rd_r;
    out_load   = 1'b0;
    out_nxt    = out_word_r;
    if (state_r == BK_IDLE) begin
      cur_nxt = q_job;
    end

    case (state_r)
      BK_CLEAR: begin
        link_we   = 1'b1;
        link_wa   = clr_h_r;
        link_wd   = (clr_s_r == LAST_SLOT) ? NULL_LINK : LW'(clr_h_r) + LW'(1);
        clr_h_nxt = clr_h_r + AW'(1);
        clr_s_nxt = (clr_s_r == LAST_SLOT) ? '0 : clr_s_r + SW'(1);
        if (clr_h_r == LAST_ADDR) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          head_nxt  = head_rv;
          state_nxt = BK_EXEC;
          if (q_job.kind == JOB_ALLOC && head_rv != NULL_LINK) begin
            link_rd_en = 1'b1;
          end
          if (q_job.kind == JOB_FREE) begin
            tag_rd_en = 1'b1;
          end
        end else begin
          cur_nxt = cur_r;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          out_load          = 1'b1;
          state_nxt         = BK_IDLE;
          out_nxt.status    = ST_NULL;
          out_nxt.out_handle = '0;
          out_nxt.bin_number = '0;
          case (cur_r.kind)
            JOB_ALLOC: begin
              out_nxt.bin_number = 4'(cur_r.bin_idx + QBIN_W'(1));
              if (head_r == NULL_LINK) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                // pop: head moves to its link, chunk tagged with its bin
                heads_we           = 1'b1;
                tag_we             = 1'b1;
                out_nxt.status     = ST_OK;
                out_nxt.out_handle = 9'(head_r);
              end
            end
            JOB_FREE: begin
              if (32'(tag_rd_r) < NUM_BINS) begin
                // push: chunk links to the old head and becomes the head
                link_we            = 1'b1;
                heads_we           = 1'b1;
                heads_wi           = tag_rd_r;
                heads_wd           = LW'(cur_r.handle);
                out_nxt.status     = ST_OK;
                out_nxt.out_handle = cur_r.handle;
                out_nxt.bin_number = 4'(32'(tag_rd_r) + 1);
              end
            end
            default: begin
              out_nxt.status = cur_r.status;
            end
          endcase
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_h_r     <= '0;
      clr_s_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_h_r <= clr_h_nxt;
      clr_s_r <= clr_s_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // job and result payload
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    head_r <= head_nxt;
    if (out_load) begin
      out_word_r <= out_nxt;
    end
  end

  // bin heads start at the first slot of each bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        heads_r[b] <= LW'(b * SLOTS_PER_BIN);
      end
    end else if (heads_we) begin
      heads_r[heads_wi] <= heads_wd;
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_rd_en) begin
      link_rd_r <= link_mem[link_ra];
    end
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (tag_rd_en) begin
      tag_rd_r <= tag_mem[tag_ra];
    end
  end

endmodule

// ===== rtl/core/segregated_pool_allocator.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake              | word
// ---------+-----------+------------------------+---------------------------
// in_      | input     | in_valid / in_stall    | spa_in_t  mode, size, handle
// out_     | output    | out_valid / out_stall  | spa_out_t status, handle, bin
// cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each request passes through the back engine as a read of the link or tag
// memory, then a commit, and the engine takes no new request before that commit;
// out_valid rises when the committed result is registered, if nothing stalls.
// After reset the back engine rewrites the link memory, with in_stall held high;
// cfg writes are taken at any time.
// in_stall rises when the two-entry queue is full; out_stall holds the result
// register and the engine waits before committing the next request.

module segregated_pool_allocator #(
  parameter int NUM_BINS      = 8,
  parameter int SLOTS_PER_BIN = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  spa_pkg::spa_in_t                in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output spa_pkg::spa_out_t               out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spa_pkg::*;

  spa_job_t front_job;
  spa_job_t q_job;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  logic     clearing;
  logic     in_take;

  assign in_stall = q_full || clearing;
  assign in_take  = in_valid && !in_stall;

  // accept and classify
  spa_front #(
    .NUM_BINS      (NUM_BINS),
    .SLOTS_PER_BIN (SLOTS_PER_BIN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .in_word   (in_word),
    .job       (front_job)
  );

  // queue between front and back
  spa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // free-list engine
  spa_back #(
    .NUM_BINS      (NUM_BINS),
    .SLOTS_PER_BIN (SLOTS_PER_BIN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
